[rtl/qprn_pkg.sv]
// shared constants, types and term tables of the quaternion product unit
package qprn_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam logic [30:0] TOL_RESET = 31'd16;
    localparam int QUEUE_DEPTH = 4;
    localparam int FRONT_STAGES = 7;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 31;

    // operand indexes of the sixteen partial products, four per component
    localparam int LIDX [16] = '{0, 1, 2, 3,  0, 1, 2, 3,  0, 2, 3, 1,  0, 3, 1, 2};
    localparam int RIDX [16] = '{0, 1, 2, 3,  1, 0, 3, 2,  2, 0, 1, 3,  3, 0, 2, 1};

    typedef struct packed {
        logic [3:0][31:0] comp;
        logic [63:0]      sum_sq;
        logic             resc;
    } t_job;

    typedef struct packed {
        logic [3:0][31:0] comp;
        logic             resc;
        logic [63:0]      n;
        logic [63:0]      r;
    } t_sq;

    typedef struct packed {
        logic [3:0][31:0] comp;
        logic             resc;
        logic [31:0]      m;
        logic [3:0]       neg;
        logic [3:0]       sat;
        logic [3:0][63:0] rem;
        logic [3:0][30:0] q;
    } t_dv;

endpackage

[rtl/qprn_front.sv]
// front pipeline: hamilton product, squared norm and rescale decision
module qprn_front #(
    parameter int FRAC_BITS = qprn_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_left_scalar,
    input  logic signed [31:0] i_left_i,
    input  logic signed [31:0] i_left_j,
    input  logic signed [31:0] i_left_k,
    input  logic signed [31:0] i_right_scalar,
    input  logic signed [31:0] i_right_i,
    input  logic signed [31:0] i_right_j,
    input  logic signed [31:0] i_right_k,
    input  logic [30:0]        i_tol,
    input  logic               i_q_full,
    output logic               o_push,
    output qprn_pkg::t_job     o_job
);

    localparam int NS = qprn_pkg::FRONT_STAGES;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAXV = 66'sd2147483647;
    localparam logic signed [65:0] MINV = -66'sd2147483648;

    logic [NS-1:0] r_vld;
    logic          en;

    logic signed [31:0] lop [4];
    logic signed [31:0] rop [4];

    logic signed [63:0] r_pm [16];
    logic signed [64:0] r_pa [4];
    logic signed [64:0] r_pb [4];
    logic [3:0][31:0]   r_c3, r_c4, r_c5, r_c6, r_c7;
    logic [63:0]        r_sq [4];
    logic [63:0]        r_b0, r_b1;
    logic [63:0]        r_s6, r_s7;
    logic               r_resc;

    logic [3:0][31:0]   n_c3;
    logic [64:0]        sum65;
    logic [63:0]        nq, one, dev;

    assign en = ~r_vld[NS-1] | ~i_q_full;
    assign o_in_ready = en;
    assign o_push = r_vld[NS-1] & ~i_q_full;

    assign lop[0] = i_left_scalar;
    assign lop[1] = i_left_i;
    assign lop[2] = i_left_j;
    assign lop[3] = i_left_k;
    assign rop[0] = i_right_scalar;
    assign rop[1] = i_right_i;
    assign rop[2] = i_right_j;
    assign rop[3] = i_right_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_in_valid};
        end
    end

    // partial products, then pair sums with the hamilton signs
    for (genvar t = 0; t < 16; t++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pm[t] <= lop[qprn_pkg::LIDX[t]] * rop[qprn_pkg::RIDX[t]];
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_comp
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (c == 0) begin
                    r_pa[c] <= 65'(r_pm[4*c]) - 65'(r_pm[4*c+1]);
                    r_pb[c] <= -65'(r_pm[4*c+2]) - 65'(r_pm[4*c+3]);
                end else begin
                    r_pa[c] <= 65'(r_pm[4*c]) + 65'(r_pm[4*c+1]);
                    r_pb[c] <= 65'(r_pm[4*c+2]) - 65'(r_pm[4*c+3]);
                end
            end
        end
        // round half up at the fraction point and saturate
        always_comb begin
            sum = 66'(r_pa[c]) + 66'(r_pb[c]) + HALF;
            sh  = sum >>> FRAC_BITS;
            if (sh > MAXV) begin
                n_c3[c] = 32'h7fffffff;
            end else if (sh < MINV) begin
                n_c3[c] = 32'h80000000;
            end else begin
                n_c3[c] = sh[31:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[c] <= 64'($signed(r_c3[c]) * $signed(r_c3[c]));
            end
        end
    end

    assign sum65 = {1'b0, r_b0} + {1'b0, r_b1};
    assign one   = 64'(1) << FRAC_BITS;
    assign nq    = (r_s6 >> FRAC_BITS) + 64'(r_s6[FRAC_BITS-1]);
    assign dev   = (nq > one) ? (nq - one) : (one - nq);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3   <= n_c3;
            r_c4   <= r_c3;
            r_c5   <= r_c4;
            r_c6   <= r_c5;
            r_c7   <= r_c6;
            r_b0   <= {1'b0, r_sq[0][62:0]} + {1'b0, r_sq[1][62:0]};
            r_b1   <= {1'b0, r_sq[2][62:0]} + {1'b0, r_sq[3][62:0]};
            r_s6   <= sum65[64] ? '1 : sum65[63:0];
            r_s7   <= r_s6;
            r_resc <= (r_s6 != 64'd0) && (dev > 64'(i_tol));
        end
    end

    assign o_job.comp   = r_c7;
    assign o_job.sum_sq = r_s7;
    assign o_job.resc   = r_resc;

endmodule

[rtl/qprn_queue.sv]
// short item queue between the front and back pipelines
module qprn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qprn_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output qprn_pkg::t_job o_job
);

    localparam int D  = qprn_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    qprn_pkg::t_job r_mem [D];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt;

    assign o_full     = (r_cnt == (AW+1)'(D));
    assign o_nonempty = (r_cnt != '0);
    assign o_job      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(D - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(D - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[rtl/qprn_back.sv]
// back pipeline: norm square root, per-component division, output register
module qprn_back #(
    parameter int FRAC_BITS = qprn_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_have,
    input  qprn_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_prod_scalar,
    output logic signed [31:0] o_prod_i,
    output logic signed [31:0] o_prod_j,
    output logic signed [31:0] o_prod_k,
    output logic               o_was_rescaled
);

    localparam int NSQ = qprn_pkg::SQRT_STEPS;
    localparam int NDV = qprn_pkg::DIV_STEPS;
    localparam int NV  = NSQ + 1 + NDV;

    logic          en;
    logic [NV-1:0] r_v;
    logic          r_out_vld;

    qprn_pkg::t_sq r_sq [NSQ];
    qprn_pkg::t_dv r_nm;
    qprn_pkg::t_dv r_dv [NDV];
    logic [3:0][31:0] r_out;
    logic             r_out_resc;

    qprn_pkg::t_dv n_nm;
    logic [3:0][31:0] n_out;

    assign en    = ~r_out_vld | i_out_ready;
    assign o_pop = en & i_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_v       <= {r_v[NV-2:0], o_pop};
            r_out_vld <= r_v[NV-1];
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        qprn_pkg::t_sq prv, nxt;
        logic [63:0] bit_k;
        assign bit_k = 64'(1) << (62 - 2*k);
        if (k == 0) begin : g_first
            always_comb begin
                prv.comp = i_job.comp;
                prv.resc = i_job.resc;
                prv.n    = i_job.sum_sq;
                prv.r    = '0;
            end
        end else begin : g_next
            assign prv = r_sq[k-1];
        end
        always_comb begin
            nxt = prv;
            if (prv.n >= prv.r + bit_k) begin
                nxt.n = prv.n - (prv.r + bit_k);
                nxt.r = (prv.r >> 1) + bit_k;
            end else begin
                nxt.r = prv.r >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k] <= nxt;
            end
        end
    end

    // dividend set-up with half-divisor rounding and overflow check
    always_comb begin
        logic [31:0] mag;
        logic [63:0] num;
        n_nm.comp = r_sq[NSQ-1].comp;
        n_nm.resc = r_sq[NSQ-1].resc;
        n_nm.m    = r_sq[NSQ-1].r[31:0];
        n_nm.q    = '0;
        for (int c = 0; c < 4; c++) begin
            n_nm.neg[c] = n_nm.comp[c][31];
            mag = n_nm.neg[c] ? (32'd0 - n_nm.comp[c]) : n_nm.comp[c];
            num = (64'(mag) << FRAC_BITS) + 64'(n_nm.m >> 1);
            n_nm.sat[c] = (num >= (64'(n_nm.m) << 31));
            n_nm.rem[c] = num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm <= n_nm;
        end
    end

    // restoring division, one quotient bit per stage on all four lanes
    for (genvar j = 0; j < NDV; j++) begin : g_div
        qprn_pkg::t_dv prv, nxt;
        logic [63:0] d;
        if (j == 0) begin : g_first
            assign prv = r_nm;
        end else begin : g_next
            assign prv = r_dv[j-1];
        end
        assign d = 64'(prv.m) << (NDV - 1 - j);
        always_comb begin
            nxt = prv;
            for (int c = 0; c < 4; c++) begin
                if (!prv.sat[c] && (prv.rem[c] >= d)) begin
                    nxt.rem[c] = prv.rem[c] - d;
                    nxt.q[c][NDV-1-j] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[j] <= nxt;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (!r_dv[NDV-1].resc) begin
                n_out[c] = r_dv[NDV-1].comp[c];
            end else if (r_dv[NDV-1].sat[c]) begin
                n_out[c] = r_dv[NDV-1].neg[c] ? 32'h80000000 : 32'h7fffffff;
            end else if (r_dv[NDV-1].neg[c]) begin
                n_out[c] = 32'd0 - {1'b0, r_dv[NDV-1].q[c]};
            end else begin
                n_out[c] = {1'b0, r_dv[NDV-1].q[c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out      <= n_out;
            r_out_resc <= r_dv[NDV-1].resc;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_prod_scalar  = r_out[0];
    assign o_prod_i       = r_out[1];
    assign o_prod_j       = r_out[2];
    assign o_prod_k       = r_out[3];
    assign o_was_rescaled = r_out_resc;

endmodule

[rtl/quaternion_product_renormalize_unit.sv]
// Quaternion Hamilton product with norm check and renormalization. One
// item is taken per cycle unless a full queue stalls the front. Items
// pass seven front stages (multiply, sum, round, square, norm sum,
// tolerance check), the four-entry queue, 32 square-root stages, one
// dividend stage, 31 quotient stages and the output register. The
// tolerance register is written through the cfg channel, which is always
// ready, and is meant to change only while no item is in flight.
module quaternion_product_renormalize_unit #(
    parameter int FRAC_BITS = qprn_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_left_scalar,
    input  logic signed [31:0] i_left_i,
    input  logic signed [31:0] i_left_j,
    input  logic signed [31:0] i_left_k,
    input  logic signed [31:0] i_right_scalar,
    input  logic signed [31:0] i_right_i,
    input  logic signed [31:0] i_right_j,
    input  logic signed [31:0] i_right_k,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_prod_scalar,
    output logic signed [31:0] o_prod_i,
    output logic signed [31:0] o_prod_j,
    output logic signed [31:0] o_prod_k,
    output logic               o_was_rescaled
);

    logic [30:0]    r_tol;
    logic           q_full, q_nonempty, push, pop;
    qprn_pkg::t_job f_job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qprn_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    qprn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_scalar  (i_left_scalar),
        .i_left_i       (i_left_i),
        .i_left_j       (i_left_j),
        .i_left_k       (i_left_k),
        .i_right_scalar (i_right_scalar),
        .i_right_i      (i_right_i),
        .i_right_j      (i_right_j),
        .i_right_k      (i_right_k),
        .i_tol          (r_tol),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (f_job)
    );

    qprn_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (f_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_job      (q_job)
    );

    qprn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_have         (q_nonempty),
        .i_job          (q_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_prod_scalar  (o_prod_scalar),
        .o_prod_i       (o_prod_i),
        .o_prod_j       (o_prod_j),
        .o_prod_k       (o_prod_k),
        .o_was_rescaled (o_was_rescaled)
    );

endmodule

[rtl/qprn_checker.sv]
// port-level checks of the quaternion product unit, bound to the top level
module qprn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_cfg_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_prod_scalar,
    input logic signed [31:0] o_prod_i,
    input logic signed [31:0] o_prod_j,
    input logic signed [31:0] o_prod_k,
    input logic               o_was_rescaled
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_prod_scalar) && $stable(o_prod_i)
            && $stable(o_prod_j) && $stable(o_prod_k) && $stable(o_was_rescaled))
        else $error("result item changed while stalled");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("cfg channel not ready");

    // a rescaled result item is never all zero
    a_resc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_rescaled |-> (o_prod_scalar != 0) || (o_prod_i != 0)
            || (o_prod_j != 0) || (o_prod_k != 0))
        else $error("rescaled item is all zero");

endmodule

bind quaternion_product_renormalize_unit qprn_checker u_qprn_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_cfg_ready    (o_cfg_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_prod_scalar  (o_prod_scalar),
    .o_prod_i       (o_prod_i),
    .o_prod_j       (o_prod_j),
    .o_prod_k       (o_prod_k),
    .o_was_rescaled (o_was_rescaled)
);

[tb/tb_quaternion_product_renormalize_unit.sv]
// self-checking testbench of the quaternion product and renormalization unit
`timescale 1ns / 100ps

module tb_quaternion_product_renormalize_unit;

    localparam int FB = qprn_pkg::FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [30:0] TOL_MAX = 31'd1073741824;
    localparam logic signed [31:0] Q_ONE = 32'sd1073741824;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    typedef logic signed [31:0] t_quat [4];

    typedef struct {
        logic signed [31:0] c [4];
        logic               resc;
    } t_prod;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [30:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_left_scalar = '0;
    logic signed [31:0] i_left_i = '0;
    logic signed [31:0] i_left_j = '0;
    logic signed [31:0] i_left_k = '0;
    logic signed [31:0] i_right_scalar = '0;
    logic signed [31:0] i_right_i = '0;
    logic signed [31:0] i_right_j = '0;
    logic signed [31:0] i_right_k = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_prod_scalar;
    logic signed [31:0] o_prod_i;
    logic signed [31:0] o_prod_j;
    logic signed [31:0] o_prod_k;
    logic               o_was_rescaled;

    quaternion_product_renormalize_unit dut (.*);

    always #5 i_clk = ~i_clk;

    logic [30:0] tolerance;
    t_prod       pending_prods [$];
    int          mismatches = 0;
    int          idle_count = 0;
    bit          quiet = 1'b0;
    bit          timed_out = 1'b0;

    // exact sum of four signed partial products, rounded half up, saturated
    function automatic logic signed [31:0] round_sum(logic signed [66:0] acc);
        logic signed [66:0] r;
        r = (acc + (67'sd1 <<< (FB - 1))) >>> FB;
        if (r > 67'sd2147483647) return Q_MAX;
        if (r < -67'sd2147483648) return Q_MIN;
        return r[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_prod hamilton_renorm(t_quat a, t_quat b);
        t_prod       p;
        logic signed [66:0] s0, s1, s2, s3;
        logic [65:0] ssum;
        logic [63:0] sq, nq, dev, m;
        logic [95:0] q;
        logic [31:0] mag;
        logic        neg;
        s0 = 67'(a[0]*b[0]) - 67'(a[1]*b[1]) - 67'(a[2]*b[2]) - 67'(a[3]*b[3]);
        s1 = 67'(a[0]*b[1]) + 67'(a[1]*b[0]) + 67'(a[2]*b[3]) - 67'(a[3]*b[2]);
        s2 = 67'(a[0]*b[2]) + 67'(a[2]*b[0]) + 67'(a[3]*b[1]) - 67'(a[1]*b[3]);
        s3 = 67'(a[0]*b[3]) + 67'(a[3]*b[0]) + 67'(a[1]*b[2]) - 67'(a[2]*b[1]);
        p.c[0] = round_sum(s0);
        p.c[1] = round_sum(s1);
        p.c[2] = round_sum(s2);
        p.c[3] = round_sum(s3);
        ssum = '0;
        for (int i = 0; i < 4; i++) ssum += 66'(64'(p.c[i] * p.c[i]));
        sq = (ssum > 66'h0ffffffffffffffff) ? 64'hffffffffffffffff : ssum[63:0];
        nq = (sq >> FB) + ((sq >> (FB - 1)) & 64'd1);
        dev = (nq > (64'd1 << FB)) ? nq - (64'd1 << FB) : (64'd1 << FB) - nq;
        p.resc = (sq != 0) && (dev > 64'(tolerance));
        if (p.resc) begin
            m = int_sqrt(sq);
            for (int i = 0; i < 4; i++) begin
                neg = p.c[i][31];
                mag = neg ? 32'(-64'(p.c[i])) : p.c[i];
                q = ((96'(mag) << FB) + 96'(m >> 1)) / 96'(m);
                if (q > 96'h80000000) q = 96'h80000000;
                if (!neg && q == 96'h80000000) p.c[i] = Q_MAX;
                else p.c[i] = neg ? 32'(-q[32:0]) : q[31:0];
            end
        end
        return p;
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic send_pair(t_quat a, t_quat b);
        idle_burst();
        i_in_valid <= 1'b1;
        {i_left_scalar, i_left_i, i_left_j, i_left_k} <= {a[0], a[1], a[2], a[3]};
        {i_right_scalar, i_right_i, i_right_j, i_right_k} <= {b[0], b[1], b[2], b[3]};
        do @(posedge i_clk); while (!o_in_ready);
        pending_prods.push_back(hamilton_renorm(a, b));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_prods.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [30:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tolerance = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'($urandom_range(0, 2**20)) - 32'sd524288;
            3: return Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    // near-unit quaternion: one large component with small noise on the rest
    function automatic t_quat rand_unit();
        t_quat q;
        int    big;
        big = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
            q[i] = 32'($urandom_range(0, 2**22)) - 32'sd2097152;
        q[big] = ($urandom_range(0, 1) ? Q_ONE : -Q_ONE) + q[big];
        return q;
    endfunction

    task automatic test_directed();
        t_quat z = '{0, 0, 0, 0};
        t_quat one = '{Q_ONE, 0, 0, 0};
        t_quat hi = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX};
        t_quat lo = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN};
        t_quat ii = '{0, Q_ONE, 0, 0};
        t_quat jj = '{0, 0, Q_ONE, 0};
        t_quat kk = '{0, 0, 0, Q_ONE};
        t_quat half = '{32'sd536870912, 32'sd536870912, 32'sd536870912, 32'sd536870912};
        t_quat tiny = '{32'sd1, 32'sd0, 32'sd0, 32'sd0};
        send_pair(one, one);
        send_pair(z, hi);
        send_pair(ii, jj);
        send_pair(jj, kk);
        send_pair(kk, ii);
        send_pair(ii, ii);
        send_pair(half, half);
        send_pair(hi, hi);
        send_pair(lo, lo);
        send_pair(hi, lo);
        send_pair(lo, one);
        send_pair(tiny, tiny);
        send_pair(tiny, one);
        send_pair('{32'sd1073741840, 0, 0, 0}, one);
        send_pair('{32'sd1073741832, 0, 0, 0}, one);
        send_pair('{-32'sd1, -32'sd1, -32'sd1, -32'sd1}, lo);
        wait_drained();
    endtask

    task automatic test_tolerance_settings();
        logic [30:0] settings [4] = '{31'd0, TOL_MAX, 31'h7fffffff, 31'd4096};
        foreach (settings[s]) begin
            write_tolerance(settings[s]);
            repeat (20) send_pair(rand_unit(), rand_unit());
            send_pair('{Q_MAX, Q_MIN, Q_MAX, Q_MIN}, '{Q_MIN, Q_MAX, Q_MIN, Q_MAX});
            wait_drained();
        end
        write_tolerance(qprn_pkg::TOL_RESET);
    endtask

    task automatic test_random(int count);
        t_quat a, b;
        repeat (count) begin
            if ($urandom_range(0, 3) != 0) begin
                a = rand_unit();
                b = rand_unit();
            end else begin
                foreach (a[i]) a[i] = rand_comp();
                foreach (b[i]) b[i] = rand_comp();
            end
            send_pair(a, b);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_prod e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_prods.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected product item");
            end else begin
                e = pending_prods.pop_front();
                if ({o_prod_scalar, o_prod_i, o_prod_j, o_prod_k, o_was_rescaled}
                    !== {e.c[0], e.c[1], e.c[2], e.c[3], e.resc}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                                 e.c[0], e.c[1], e.c[2], e.c[3], e.resc,
                                 o_prod_scalar, o_prod_i, o_prod_j, o_prod_k,
                                 o_was_rescaled);
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("quaternion_product_renormalize_unit test failed");
            $finish;
        end
    end

    initial begin
        tolerance = qprn_pkg::TOL_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_tolerance_settings();
        test_random(1300);
        quiet = 1'b1;
        test_random(200);
        wait_drained();
        if (mismatches == 0 && pending_prods.size() == 0)
            $display("quaternion_product_renormalize_unit test passed");
        else
            $display("quaternion_product_renormalize_unit test failed");
        $finish;
    end

endmodule
